@@ hdl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, a, b)
`endif
`endif

@@ hdl/ppte_pkg.sv @@
// Shared types and constants of the trajectory evaluator.
package ppte_pkg;
    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int POLY_TERMS_DEF = 6;
    localparam int AXES = 3;
    localparam logic [1:0] CMD_LOAD_COEF = 2'd0;
    localparam logic [1:0] CMD_LOAD_DUR = 2'd1;
    localparam logic [1:0] CMD_EVAL = 2'd2;
    localparam logic [1:0] DERIV_ACC = 2'd2;
    localparam logic REG_SEGS = 1'b0;
    localparam logic REG_TOL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_WALK_RD, ST_WALK, ST_MUL, ST_ACC, ST_DONE
    } ppte_state_t;

    // controller to datapath
    typedef struct packed {
        logic start;      // latch request
        logic walk_rd;    // read duration of current segment
        logic walk_step;  // compare/advance on read duration
        logic mul_rd;     // read coefficient and multiply
        logic acc;        // shift, add, saturate
        logic out_load;   // move result to output register
    } ppte_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_done;
        logic last_term;
        logic last_axis;
    } ppte_stat_t;
endpackage

@@ hdl/ppte_ctrl.sv @@
// Controller state machine of the trajectory evaluator.
module ppte_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_go,
    input  ppte_pkg::ppte_stat_t stat,
    input  logic              out_free,
    output ppte_pkg::ppte_cmd_t  cmd,
    output logic              busy
);
    import ppte_pkg::*;

    ppte_state_t state_reg, state_next;

    // hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // sequence walk, then terms and axes
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (req_go) begin
                    cmd.start = 1'b1;
                    state_next = ST_WALK_RD;
                end
            end
            ST_WALK_RD: begin
                cmd.walk_rd = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                cmd.walk_step = 1'b1;
                state_next = stat.walk_done ? ST_MUL : ST_WALK_RD;
            end
            ST_MUL: begin
                cmd.mul_rd = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                state_next = (stat.last_term && stat.last_axis) ? ST_DONE : ST_MUL;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

@@ hdl/ppte_dp.sv @@
// Datapath: stores, segment walk and shared Horner multiplier.
module ppte_dp #(
    parameter int MAX_SEGMENTS = ppte_pkg::MAX_SEGMENTS_DEF,
    parameter int POLY_TERMS = ppte_pkg::POLY_TERMS_DEF
) (
    input  logic               aclk,
    input  logic               ld_coef,
    input  logic               ld_dur,
    input  logic [3:0]         in_seg,
    input  logic [1:0]         in_axis,
    input  logic [2:0]         in_ci,
    input  logic signed [31:0] in_value,
    input  logic [31:0]        in_time,
    input  logic [1:0]         in_deriv,
    input  logic [4:0]         segs_cfg,
    input  logic [15:0]        tol_cfg,
    input  ppte_pkg::ppte_cmd_t cmd,
    output ppte_pkg::ppte_stat_t stat,
    output logic [103:0]       res
);
    import ppte_pkg::*;

    localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int DEPTH = MAX_SEGMENTS * AXES * POLY_TERMS;
    localparam int AW = $clog2(DEPTH);
    localparam int TW = $clog2(POLY_TERMS + 1);
    localparam int UW = $clog2(MAX_SEGMENTS + 1);
    // negative durations make the remaining time grow on every step
    localparam int TTW = 34 + SW;

    logic signed [31:0] coef_mem [DEPTH];
    logic signed [31:0] dur_mem [MAX_SEGMENTS];
    logic signed [31:0] coef_rd_reg;
    logic signed [31:0] dur_rd_reg;

    logic [SW-1:0]      idx_reg;
    logic [UW-1:0]      used_reg;
    logic [TTW-1:0]     t_reg;       // remaining time, signed, never negative
    logic [31:0]        te_reg;      // clamped time for evaluation
    logic [15:0]        tol_reg;
    logic [1:0]         k_reg;
    logic [1:0]         ax_reg;
    logic [TW-1:0]      i_reg;       // current power
    logic signed [31:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic signed [39:0] cs;          // scaled coefficient
    logic               past_reg, clip_reg;
    logic signed [31:0] rx_reg, ry_reg;
    logic [103:0]       res_reg;

    // walk compare
    logic signed [TTW-1:0] d_ext, diff;
    logic               go_on;
    logic               walk_end;
    logic [TW-1:0]      n_terms;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [TW-1:0]      pos;
    logic signed [7:0]  mult;
    logic signed [65:0] sum;
    logic signed [31:0] sat_v;
    logic               sat_c;
    logic [UW-1:0]      used_lim;

    assign d_ext = {{(TTW-32){dur_rd_reg[31]}}, dur_rd_reg};
    assign diff = $signed(t_reg) - d_ext;
    assign go_on = ($signed(t_reg) > d_ext)
                   && (diff > $signed({{(TTW-16){1'b0}}, tol_reg}));
    assign walk_end = !go_on || (32'(idx_reg) + 1 >= 32'(used_reg));
    assign n_terms = TW'(POLY_TERMS) - TW'(k_reg);
    assign pos = TW'(POLY_TERMS - 1) - i_reg - TW'(k_reg);
    assign rd_addr = AW'((32'(idx_reg) * AXES + 32'(ax_reg)) * POLY_TERMS + 32'(pos));
    assign wr_addr = AW'((32'(in_seg) * AXES + 32'(in_axis)) * POLY_TERMS + 32'(in_ci));

    always_comb begin
        if (segs_cfg == 5'd0) used_lim = UW'(1);
        else if (32'(segs_cfg) > MAX_SEGMENTS) used_lim = UW'(MAX_SEGMENTS);
        else used_lim = UW'(segs_cfg);
    end

    // power multiplier for derivatives
    always_comb begin
        case (k_reg)
            2'd1: mult = 8'(i_reg) + 8'sd1;
            2'd2: mult = 8'((8'(i_reg) + 8'd1) * (8'(i_reg) + 8'd2));
            default: mult = 8'sd1;
        endcase
    end

    // floor shift, add, saturate
    assign sum = 66'(prod_reg >>> 16) + 66'(cs);
    always_comb begin
        sat_c = 1'b0;
        sat_v = sum[31:0];
        if (sum > 66'sd2147483647) begin
            sat_v = 32'h7FFFFFFF; sat_c = 1'b1;
        end else if (sum < -66'sd2147483648) begin
            sat_v = 32'h80000000; sat_c = 1'b1;
        end
    end

    // write and read stores
    always_ff @(posedge aclk) begin
        if (ld_coef && 32'(in_seg) < MAX_SEGMENTS && in_axis < 2'(AXES)
            && 32'(in_ci) < POLY_TERMS) begin
            coef_mem[wr_addr] <= in_value;
        end
        if (ld_dur && 32'(in_seg) < MAX_SEGMENTS) begin
            dur_mem[SW'(in_seg)] <= in_value;
        end
        if (cmd.mul_rd) coef_rd_reg <= coef_mem[rd_addr];
        if (cmd.walk_rd) dur_rd_reg <= dur_mem[idx_reg];
    end

    // walk and Horner registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            t_reg <= {{(TTW-32){1'b0}}, in_time};
            idx_reg <= '0;
            used_reg <= used_lim;
            tol_reg <= tol_cfg;
            k_reg <= in_deriv;
            past_reg <= 1'b0;
            clip_reg <= 1'b0;
            ax_reg <= '0;
            acc_reg <= '0;
        end
        if (cmd.walk_step) begin
            if (go_on) begin
                if (32'(idx_reg) + 1 >= 32'(used_reg)) begin
                    past_reg <= 1'b1;
                end else begin
                    t_reg <= diff;
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (walk_end) begin
                i_reg <= n_terms - 1'b1;
                te_reg <= (|t_reg[TTW-1:32]) ? 32'hFFFFFFFF : t_reg[31:0];
            end
        end
        if (cmd.mul_rd) begin
            prod_reg <= 64'(acc_reg) * $signed({1'b0, te_reg});
        end
        if (cmd.acc) begin
            if (sat_c) clip_reg <= 1'b1;
            if (i_reg == '0) begin
                acc_reg <= '0;
                i_reg <= n_terms - 1'b1;
                ax_reg <= ax_reg + 1'b1;
                if (ax_reg == 2'd0) rx_reg <= sat_v;
                if (ax_reg == 2'd1) ry_reg <= sat_v;
                if (ax_reg == 2'd2) begin
                    res_reg <= {past_reg, clip_reg | sat_c, 4'(idx_reg), sat_v,
                                ry_reg, rx_reg};
                end
            end else begin
                acc_reg <= sat_v;
                i_reg <= i_reg - 1'b1;
            end
        end
    end

    // scaled coefficient follows the read
    assign cs = 40'(coef_rd_reg) * 40'(mult);

    assign stat.walk_done = walk_end;
    assign stat.last_term = (i_reg == '0);
    assign stat.last_axis = (ax_reg == 2'd2);
    assign res = res_reg;
endmodule

@@ hdl/piecewise_poly_traj_eval.sv @@
// Top level of the piecewise polynomial trajectory evaluator.
// Usage: load durations (cmd 1) and coefficients (cmd 0) through the
// s_axis request channel; each load gives no result.
// An evaluate request (cmd 2, deriv 0..2) gives one m_axis result with
// x, y, z, segment, saturated and past_end. Other codes are dropped.
// An evaluate request walks the segments, reading and comparing the
// duration of each segment visited, then runs the Horner terms on each of
// three axes through one shared 32x33 multiplier, and then loads the
// output register, which raises m_axis_tvalid.
// One evaluate is in flight at a time; the next request is taken in the
// cycle after the result is loaded.
// The finished result waits in the output register; a new request is
// taken while it waits, and the next result waits for m_axis_tready.
// Reset clears control state, sets segments_in_use to 1 and
// join_tolerance to 33; the stores are undefined until loaded.
// Configuration: cfg_we with cfg_index 0 or 1 while idle.
module piecewise_poly_traj_eval #(
    parameter int MAX_SEGMENTS = ppte_pkg::MAX_SEGMENTS_DEF,
    parameter int POLY_TERMS = ppte_pkg::POLY_TERMS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd[1:0] seg_index[5:2] axis[7:6] coef_index[10:8] value[42:11]
    // query_time[74:43] deriv[76:75], zero pad to 80
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x[31:0] out_y[63:32] out_z[95:64] segment[99:96] saturated[100]
    // past_end[101], zero pad to 104
    output logic [103:0] m_axis_tdata
);
    import ppte_pkg::*;

    logic [4:0]  segs_reg;
    logic [15:0] tol_reg;
    logic        busy, acc_in, is_eval, out_free;
    logic        mvalid_reg;
    logic [103:0] res;
    ppte_cmd_t   cmd;
    ppte_stat_t  stat;

    // write configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            segs_reg <= 5'd1;
            tol_reg <= 16'd33;
        end else if (cfg_we) begin
            if (cfg_index == REG_SEGS) segs_reg <= cfg_data[4:0];
            if (cfg_index == REG_TOL) tol_reg <= cfg_data;
        end
    end

    assign s_axis_tready = !busy;
    assign acc_in = s_axis_tvalid && s_axis_tready;
    assign is_eval = acc_in && s_axis_tdata[1:0] == CMD_EVAL
                     && s_axis_tdata[76:75] <= DERIV_ACC;
    assign out_free = !mvalid_reg || m_axis_tready;

    ppte_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .req_go(is_eval), .stat(stat),
        .out_free(out_free), .cmd(cmd), .busy(busy)
    );

    ppte_dp #(.MAX_SEGMENTS(MAX_SEGMENTS), .POLY_TERMS(POLY_TERMS)) u_dp (
        .aclk(aclk),
        .ld_coef(acc_in && s_axis_tdata[1:0] == CMD_LOAD_COEF),
        .ld_dur(acc_in && s_axis_tdata[1:0] == CMD_LOAD_DUR),
        .in_seg(s_axis_tdata[5:2]), .in_axis(s_axis_tdata[7:6]),
        .in_ci(s_axis_tdata[10:8]), .in_value(s_axis_tdata[42:11]),
        .in_time(s_axis_tdata[74:43]), .in_deriv(s_axis_tdata[76:75]),
        .segs_cfg(segs_reg), .tol_cfg(tol_reg), .cmd(cmd), .stat(stat), .res(res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            mvalid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            mvalid_reg <= 1'b0;
        end
        if (cmd.out_load) m_axis_tdata <= {2'b00, res[101:0]};
    end
    assign m_axis_tvalid = mvalid_reg;

`include "assert_macros.svh"
    `ASSERT_NEXT(a_start_busy, aclk, aresetn, is_eval, busy)
    `ASSERT_NEXT(a_load_valid, aclk, aresetn, cmd.out_load, m_axis_tvalid)
    `ASSERT_IMPL(a_load_free, aclk, aresetn, cmd.out_load |-> out_free)
endmodule
